[hw/rtl/osc52_pkg.sv]
// ----------------------------------------------------------------------------
// OSC 52 filter package
// Byte codes, parser state codes and the result item type used by the filter;
// the stream interfaces take the byte width from here.
// ----------------------------------------------------------------------------
package osc52_pkg;

    localparam int ByteW  = 8;
    localparam int StateW = 4;

    // Byte codes of interest
    localparam logic [ByteW-1:0] C_ESC   = 8'h1b;
    localparam logic [ByteW-1:0] C_OSC   = 8'h9d;
    localparam logic [ByteW-1:0] C_ST    = 8'h9c;
    localparam logic [ByteW-1:0] C_BEL   = 8'h07;
    localparam logic [ByteW-1:0] C_RBR   = 8'h5d;
    localparam logic [ByteW-1:0] C_BSL   = 8'h5c;
    localparam logic [ByteW-1:0] C_FIVE  = 8'h35;
    localparam logic [ByteW-1:0] C_TWO   = 8'h32;
    localparam logic [ByteW-1:0] C_SEMI  = 8'h3b;
    localparam logic [ByteW-1:0] C_QUERY = 8'h3f;

    // Parser state codes
    localparam logic [StateW-1:0] S_IDLE      = 4'd0;
    localparam logic [StateW-1:0] S_ESC       = 4'd1;
    localparam logic [StateW-1:0] S_OSC       = 4'd2;
    localparam logic [StateW-1:0] S_5         = 4'd3;
    localparam logic [StateW-1:0] S_52        = 4'd4;
    localparam logic [StateW-1:0] S_CAP       = 4'd5;
    localparam logic [StateW-1:0] S_CAP_ESC   = 4'd6;
    localparam logic [StateW-1:0] S_OTHER     = 4'd7;
    localparam logic [StateW-1:0] S_OTHER_ESC = 4'd8;

    typedef struct packed {
        logic             capture_valid;
        logic [ByteW-1:0] capture_byte;
        logic             paste_done;
        logic             paste_cancel;
    } capture_result_t;

endpackage

[hw/rtl/osc52_byte_if.sv]
// ----------------------------------------------------------------------------
// OSC 52 byte stream interface
// Valid/ready channel carrying one terminal output byte per item.
// ----------------------------------------------------------------------------
interface osc52_byte_if;
    logic                         valid;
    logic                         ready;
    logic [osc52_pkg::ByteW-1:0]  byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

[hw/rtl/osc52_capture_if.sv]
// ----------------------------------------------------------------------------
// OSC 52 capture stream interface
// Valid/ready channel carrying one filter result item per input byte.
// ----------------------------------------------------------------------------
interface osc52_capture_if;
    logic                         valid;
    logic                         ready;
    logic                         capture_valid;
    logic [osc52_pkg::ByteW-1:0]  capture_byte;
    logic                         paste_done;
    logic                         paste_cancel;

    modport source (output valid, output capture_valid, output capture_byte,
                    output paste_done, output paste_cancel, input ready);
    modport sink   (input valid, input capture_valid, input capture_byte,
                    input paste_done, input paste_cancel, output ready);
endinterface

[hw/rtl/osc52_sequence_capture_filter.sv]
// ----------------------------------------------------------------------------
// OSC 52 sequence capture filter
// Watches a terminal byte stream and passes on the payload of OSC 52
// sequences, flagging paste completion and cancellation.
// ----------------------------------------------------------------------------
// Throughput: 1 byte per cycle while the skid entry is empty; the parser
//   state update is a combinational decode, and a two-entry output buffer
//   (output register plus skid) registers each result item and keeps input
//   acceptance going while one result waits downstream.
// Reset: rst_n clears the parser to idle and empties the output buffer.
// ----------------------------------------------------------------------------
module osc52_sequence_capture_filter (
    input  logic                   clk,
    input  logic                   rst_n,
    osc52_byte_if.sink             bytes,
    osc52_capture_if.source        captures
);

    // Next state for a byte that follows an ESC outside a capture.
    function automatic logic [osc52_pkg::StateW-1:0] after_esc(
        input logic [osc52_pkg::ByteW-1:0] b);
        logic [osc52_pkg::StateW-1:0] n;
        if (b == osc52_pkg::C_RBR)
            n = osc52_pkg::S_OSC;
        else if (b == osc52_pkg::C_ESC)
            n = osc52_pkg::S_ESC;
        else
            n = osc52_pkg::S_OTHER;
        return n;
    endfunction

    // Next state for a byte seen while skipping a foreign sequence.
    function automatic logic [osc52_pkg::StateW-1:0] in_other(
        input logic [osc52_pkg::ByteW-1:0] b);
        logic [osc52_pkg::StateW-1:0] n;
        if (b == osc52_pkg::C_ESC)
            n = osc52_pkg::S_OTHER_ESC;
        else if (b == osc52_pkg::C_ST || b == osc52_pkg::C_BEL)
            n = osc52_pkg::S_IDLE;
        else
            n = osc52_pkg::S_OTHER;
        return n;
    endfunction

    logic [osc52_pkg::StateW-1:0] parse_state_reg;
    logic [osc52_pkg::StateW-1:0] parse_state_next;

    osc52_pkg::capture_result_t   result;
    osc52_pkg::capture_result_t   out_data_reg;
    osc52_pkg::capture_result_t   skid_data_reg;
    logic                         out_valid_reg;
    logic                         skid_valid_reg;

    logic                         accept;
    logic                         out_load;
    logic [osc52_pkg::ByteW-1:0]  b;

    assign b           = bytes.byte_in;
    // The skid entry is the only thing that can block a new byte.
    assign bytes.ready = !skid_valid_reg;
    assign accept      = bytes.valid && !skid_valid_reg;
    assign out_load    = !out_valid_reg || captures.ready;

    // ------------------------------------------------------------------
    // Parser decode: next state and result item for the incoming byte.
    // Bytes that the parser re-examines (foreign OSC number, ESC inside
    // a payload or skipped sequence) are folded into the same decode.
    // ------------------------------------------------------------------
    always_comb
    begin
        parse_state_next     = osc52_pkg::S_IDLE;
        result.capture_valid = 1'b0;
        result.capture_byte  = '0;
        result.paste_done    = 1'b0;
        result.paste_cancel  = 1'b0;

        case (parse_state_reg)
            osc52_pkg::S_ESC:
            begin
                parse_state_next = after_esc(b);
            end
            osc52_pkg::S_OSC:
            begin
                parse_state_next = (b == osc52_pkg::C_FIVE) ? osc52_pkg::S_5 : in_other(b);
            end
            osc52_pkg::S_5:
            begin
                parse_state_next = (b == osc52_pkg::C_TWO) ? osc52_pkg::S_52 : in_other(b);
            end
            osc52_pkg::S_52:
            begin
                // Anything but ';' starts skipping without a second look.
                parse_state_next = (b == osc52_pkg::C_SEMI) ? osc52_pkg::S_CAP
                                                             : osc52_pkg::S_OTHER;
            end
            osc52_pkg::S_CAP:
            begin
                if (b == osc52_pkg::C_ESC)
                begin
                    parse_state_next = osc52_pkg::S_CAP_ESC;
                end
                else if (b == osc52_pkg::C_ST || b == osc52_pkg::C_BEL)
                begin
                    parse_state_next  = osc52_pkg::S_IDLE;
                    result.paste_done = 1'b1;
                end
                else if (b == osc52_pkg::C_QUERY)
                begin
                    // A query is not a paste: drop it and skip the rest.
                    parse_state_next    = osc52_pkg::S_OTHER;
                    result.paste_cancel = 1'b1;
                end
                else
                begin
                    parse_state_next     = osc52_pkg::S_CAP;
                    result.capture_valid = 1'b1;
                    result.capture_byte  = b;
                end
            end
            osc52_pkg::S_CAP_ESC:
            begin
                if (b == osc52_pkg::C_BSL)
                begin
                    parse_state_next  = osc52_pkg::S_IDLE;
                    result.paste_done = 1'b1;
                end
                else
                begin
                    // Abort the paste and treat the byte as following a fresh ESC.
                    parse_state_next    = after_esc(b);
                    result.paste_cancel = 1'b1;
                end
            end
            osc52_pkg::S_OTHER:
            begin
                parse_state_next = in_other(b);
            end
            osc52_pkg::S_OTHER_ESC:
            begin
                parse_state_next = (b == osc52_pkg::C_BSL) ? osc52_pkg::S_IDLE : after_esc(b);
            end
            default:
            begin
                // Idle, and any unused code behaves as idle.
                if (b == osc52_pkg::C_ESC)
                    parse_state_next = osc52_pkg::S_ESC;
                else if (b == osc52_pkg::C_OSC)
                    parse_state_next = osc52_pkg::S_OSC;
                else
                    parse_state_next = osc52_pkg::S_IDLE;
            end
        endcase
    end

    // Advance the parser only on an accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            parse_state_reg <= osc52_pkg::S_IDLE;
        else if (accept)
            parse_state_reg <= parse_state_next;
    end

    // ------------------------------------------------------------------
    // Output buffer: output register in front, skid entry behind it.
    // The skid entry fills only when a result arrives while the output
    // register is stalled, and it drains first on the next free slot.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (accept)
                out_data_reg <= result;
        end
        else if (accept)
        begin
            skid_data_reg <= result;
        end
    end

    assign captures.valid         = out_valid_reg;
    assign captures.capture_valid = out_data_reg.capture_valid;
    assign captures.capture_byte  = out_data_reg.capture_byte;
    assign captures.paste_done    = out_data_reg.paste_done;
    assign captures.paste_cancel  = out_data_reg.paste_cancel;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The skid entry is only ever occupied behind a full output register.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry occupied with empty output register");

    // The parser holds while no byte is accepted.
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(parse_state_reg))
        else $error("parser state moved without an accepted byte");

    // A result item carries at most one of payload, done and cancel.
    a_result_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot0({out_data_reg.capture_valid,
                                    out_data_reg.paste_done,
                                    out_data_reg.paste_cancel}))
        else $error("result item flags more than one event");

    // ESC during a capture always parks in the capture-escape state.
    a_cap_esc: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && parse_state_reg == osc52_pkg::S_CAP && b == osc52_pkg::C_ESC)
        |=> parse_state_reg == osc52_pkg::S_CAP_ESC)
        else $error("ESC in payload did not enter capture-escape state");

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// OSC 52 sequence capture filter testbench
// Drives terminal byte streams into the filter and checks every result item
// against a cycle-free parser model kept in the bench. The stimulus has a
// directed part for the parser corner cases, then random streams built mostly
// from well-formed escape sequences, under three mixes of idling on both
// sides, one long output stall and one pause until the output drains.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int HalfPeriod     = 5;
    localparam int ResetCycles    = 12;
    localparam int StallLimit     = 5000;
    localparam int SettleCycles   = 4;
    localparam int PhaseItems     = 220;
    localparam int LongHoldCycles = 300;
    localparam int FillItems      = 40;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #HalfPeriod clk = ~clk;

    osc52_byte_if    bytes_if ();
    osc52_capture_if caps_if ();

    osc52_sequence_capture_filter u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .bytes    (bytes_if),
        .captures (caps_if)
    );

    // Parser model state and the results still owed by the block
    logic [osc52_pkg::StateW-1:0] parser_state = osc52_pkg::S_IDLE;
    osc52_pkg::capture_result_t   expected_captures[$];

    // Idle odds in percent for each side; long output holds asked for by the
    // tests and started by the receiver
    int src_idle_pct  = 0;
    int snk_idle_pct  = 0;
    int hold_requests = 0;
    int holds_started = 0;
    int hold_left     = 0;

    int bytes_sent   = 0;
    int idle_cycles  = 0;
    int fail_count   = 0;
    int payload_seen = 0;
    int done_seen    = 0;
    int cancel_seen  = 0;

    // ------------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------------

    // Next state for a byte that follows an ESC outside a capture.
    function automatic logic [osc52_pkg::StateW-1:0] next_after_escape(
        input logic [osc52_pkg::ByteW-1:0] b);
        if (b == osc52_pkg::C_RBR)
            return osc52_pkg::S_OSC;
        if (b == osc52_pkg::C_ESC)
            return osc52_pkg::S_ESC;
        return osc52_pkg::S_OTHER;
    endfunction

    // Next state for a byte seen while skipping a foreign sequence.
    function automatic logic [osc52_pkg::StateW-1:0] next_while_skipping(
        input logic [osc52_pkg::ByteW-1:0] b);
        if (b == osc52_pkg::C_ESC)
            return osc52_pkg::S_OTHER_ESC;
        if (b == osc52_pkg::C_ST || b == osc52_pkg::C_BEL)
            return osc52_pkg::S_IDLE;
        return osc52_pkg::S_OTHER;
    endfunction

    // Advance the parser by one byte and return the result item it causes.
    function automatic osc52_pkg::capture_result_t predict_capture(
        input logic [osc52_pkg::ByteW-1:0] b);
        osc52_pkg::capture_result_t   res;
        logic [osc52_pkg::StateW-1:0] nxt;
        res = '0;
        case (parser_state)
            osc52_pkg::S_ESC:
                nxt = next_after_escape(b);
            // A failed number byte is examined again as a skipped byte, so
            // it may already end the sequence.
            osc52_pkg::S_OSC:
                nxt = (b == osc52_pkg::C_FIVE) ? osc52_pkg::S_5 : next_while_skipping(b);
            osc52_pkg::S_5:
                nxt = (b == osc52_pkg::C_TWO) ? osc52_pkg::S_52 : next_while_skipping(b);
            // After "52" a wrong byte only starts the skip.
            osc52_pkg::S_52:
                nxt = (b == osc52_pkg::C_SEMI) ? osc52_pkg::S_CAP : osc52_pkg::S_OTHER;
            osc52_pkg::S_CAP:
            begin
                if (b == osc52_pkg::C_ESC)
                    nxt = osc52_pkg::S_CAP_ESC;
                else if (b == osc52_pkg::C_ST || b == osc52_pkg::C_BEL)
                begin
                    nxt = osc52_pkg::S_IDLE;
                    res.paste_done = 1'b1;
                end
                else if (b == osc52_pkg::C_QUERY)
                begin
                    nxt = osc52_pkg::S_OTHER;
                    res.paste_cancel = 1'b1;
                end
                else
                begin
                    nxt = osc52_pkg::S_CAP;
                    res.capture_valid = 1'b1;
                    res.capture_byte  = b;
                end
            end
            // ESC inside a payload: backslash completes, anything else
            // cancels and is read as the byte after a fresh ESC.
            osc52_pkg::S_CAP_ESC:
            begin
                if (b == osc52_pkg::C_BSL)
                begin
                    nxt = osc52_pkg::S_IDLE;
                    res.paste_done = 1'b1;
                end
                else
                begin
                    nxt = next_after_escape(b);
                    res.paste_cancel = 1'b1;
                end
            end
            osc52_pkg::S_OTHER:
                nxt = next_while_skipping(b);
            osc52_pkg::S_OTHER_ESC:
                nxt = (b == osc52_pkg::C_BSL) ? osc52_pkg::S_IDLE : next_after_escape(b);
            // Idle, and any code the parser never produces
            default:
            begin
                if (b == osc52_pkg::C_ESC)
                    nxt = osc52_pkg::S_ESC;
                else if (b == osc52_pkg::C_OSC)
                    nxt = osc52_pkg::S_OSC;
                else
                    nxt = osc52_pkg::S_IDLE;
            end
        endcase
        parser_state = nxt;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Byte sender
    // ------------------------------------------------------------------------

    // Offer one byte, idling first at the current odds, and record the
    // expected result once the block takes it. Leave valid high on return so
    // back-to-back bytes need no extra assignment in the accept step.
    task automatic send_byte(input logic [osc52_pkg::ByteW-1:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            bytes_if.valid <= 1'b0;
            @(posedge clk);
        end
        bytes_if.valid   <= 1'b1;
        bytes_if.byte_in <= b;
        do
            @(posedge clk);
        while (!bytes_if.ready);
        expected_captures.push_back(predict_capture(b));
        bytes_sent++;
    endtask

    // Drop valid and hold until every owed result item has come back.
    task automatic wait_for_results();
        bytes_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_captures.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Random sequence building blocks
    // ------------------------------------------------------------------------

    // Pick any byte value.
    function automatic logic [osc52_pkg::ByteW-1:0] any_byte();
        return 8'($urandom_range(255));
    endfunction

    // Pick a byte that neither ends nor cancels a sequence.
    function automatic logic [osc52_pkg::ByteW-1:0] plain_payload_byte();
        logic [osc52_pkg::ByteW-1:0] b;
        do
            b = any_byte();
        while (b == osc52_pkg::C_ESC || b == osc52_pkg::C_ST ||
               b == osc52_pkg::C_BEL || b == osc52_pkg::C_QUERY);
        return b;
    endfunction

    // Send the OSC introducer in its 8-bit or its two-byte form.
    task automatic send_introducer();
        if ($urandom_range(1) == 0)
            send_byte(osc52_pkg::C_OSC);
        else
        begin
            send_byte(osc52_pkg::C_ESC);
            send_byte(osc52_pkg::C_RBR);
        end
    endtask

    // Send one of the three string terminators.
    task automatic send_terminator();
        case ($urandom_range(2))
            0: send_byte(osc52_pkg::C_BEL);
            1: send_byte(osc52_pkg::C_ST);
            default:
            begin
                send_byte(osc52_pkg::C_ESC);
                send_byte(osc52_pkg::C_BSL);
            end
        endcase
    endtask

    // Send one random sequence. Nearly half are OSC 52 pastes with random
    // content; the rest are other OSC numbers, broken "52" headers, foreign
    // escapes and raw noise.
    task automatic send_random_sequence();
        int kind;
        int len;
        kind = $urandom_range(99);
        len  = $urandom_range(12);
        if (kind < 45)
        begin
            send_introducer();
            send_byte(osc52_pkg::C_FIVE);
            send_byte(osc52_pkg::C_TWO);
            send_byte(osc52_pkg::C_SEMI);
            // Mostly clean payload, now and then a raw byte that may end it
            repeat (len)
                send_byte(($urandom_range(19) == 0) ? any_byte() : plain_payload_byte());
            case ($urandom_range(9))
                0: send_byte(osc52_pkg::C_QUERY);
                1:
                begin
                    send_byte(osc52_pkg::C_ESC);
                    send_byte(plain_payload_byte());
                end
                default: send_terminator();
            endcase
        end
        else if (kind < 60)
        begin
            // OSC, usually with a number other than 52
            send_introducer();
            if ($urandom_range(2) == 0)
            begin
                send_byte(osc52_pkg::C_FIVE);
                send_byte(plain_payload_byte());
            end
            else
                send_byte(any_byte());
            repeat (len)
                send_byte(plain_payload_byte());
            send_terminator();
        end
        else if (kind < 70)
        begin
            // "52" followed by a random byte in place of the semicolon
            send_introducer();
            send_byte(osc52_pkg::C_FIVE);
            send_byte(osc52_pkg::C_TWO);
            send_byte(any_byte());
            repeat (len)
                send_byte(plain_payload_byte());
            send_terminator();
        end
        else if (kind < 80)
        begin
            // Escape sequence with a random second byte
            send_byte(osc52_pkg::C_ESC);
            send_byte(any_byte());
            repeat (len / 2)
                send_byte(plain_payload_byte());
            send_terminator();
        end
        else
        begin
            repeat (len / 2 + 1)
                send_byte(any_byte());
        end
    endtask

    // ------------------------------------------------------------------------
    // Result receiver: random ready, or a long hold when requested
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_requests != holds_started)
        begin
            hold_left     = LongHoldCycles;
            holds_started = hold_requests;
        end
        if (hold_left > 0)
        begin
            caps_if.ready <= 1'b0;
            hold_left--;
        end
        else
            caps_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Result checker: compare each accepted item with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        osc52_pkg::capture_result_t want;
        if (rst_n && caps_if.valid && caps_if.ready)
        begin
            if (expected_captures.size() == 0)
            begin
                $error("capture item with no byte outstanding");
                fail_count++;
            end
            else
            begin
                want = expected_captures.pop_front();
                if (caps_if.capture_valid !== want.capture_valid)
                begin
                    $error("capture_valid: expected %0d, got %0d",
                           want.capture_valid, caps_if.capture_valid);
                    fail_count++;
                end
                // The byte field is defined as zero outside a payload too
                if (caps_if.capture_byte !== want.capture_byte)
                begin
                    $error("capture_byte: expected 0x%02h, got 0x%02h",
                           want.capture_byte, caps_if.capture_byte);
                    fail_count++;
                end
                if (caps_if.paste_done !== want.paste_done)
                begin
                    $error("paste_done: expected %0d, got %0d",
                           want.paste_done, caps_if.paste_done);
                    fail_count++;
                end
                if (caps_if.paste_cancel !== want.paste_cancel)
                begin
                    $error("paste_cancel: expected %0d, got %0d",
                           want.paste_cancel, caps_if.paste_cancel);
                    fail_count++;
                end
                payload_seen += int'(want.capture_valid);
                done_seen    += int'(want.paste_done);
                cancel_seen  += int'(want.paste_cancel);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when nothing moves on either side for too long
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((bytes_if.valid && bytes_if.ready) || (caps_if.valid && caps_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= StallLimit)
            begin
                $display("osc52_sequence_capture_filter test failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Walk the parser through its corner cases: byte extremes in idle and in
    // a payload, the escape-backslash end, a query cancel, repeated ESC, a
    // failed number whose byte is itself a terminator, an escape cancel followed
    // by an OSC that reopens while skipping, and "52" without its semicolon.
    task automatic test_directed_sequences();
        logic [osc52_pkg::ByteW-1:0] seq[$];
        seq = '{8'h00, 8'hff,
                osc52_pkg::C_OSC, osc52_pkg::C_FIVE, osc52_pkg::C_TWO,
                osc52_pkg::C_SEMI, 8'h00, 8'hff, osc52_pkg::C_ESC, osc52_pkg::C_BSL,
                osc52_pkg::C_ESC, osc52_pkg::C_RBR, osc52_pkg::C_FIVE,
                osc52_pkg::C_TWO, osc52_pkg::C_SEMI, osc52_pkg::C_QUERY,
                osc52_pkg::C_ST,
                osc52_pkg::C_ESC, osc52_pkg::C_ESC, osc52_pkg::C_RBR,
                osc52_pkg::C_FIVE, osc52_pkg::C_BEL,
                osc52_pkg::C_OSC, osc52_pkg::C_FIVE, osc52_pkg::C_TWO,
                osc52_pkg::C_SEMI, osc52_pkg::C_ESC, 8'h71,
                osc52_pkg::C_ESC, osc52_pkg::C_RBR, osc52_pkg::C_FIVE,
                osc52_pkg::C_TWO, 8'h78, osc52_pkg::C_BEL};
        src_idle_pct = 7;
        snk_idle_pct = 83;
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    // Send random sequences until the given number of bytes has gone in.
    task automatic test_random_stream(input int items, input int src_pct, input int snk_pct);
        int target;
        target       = bytes_sent + items;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        while (bytes_sent < target)
            send_random_sequence();
    endtask

    // Hold the output off for a long stretch while bytes keep coming, so the
    // output buffer fills and the block stalls its input.
    task automatic test_output_backpressure();
        int target;
        target       = bytes_sent + FillItems;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_requests++;
        while (bytes_sent < target)
            send_random_sequence();
    endtask

    // Stop in the middle of the stream until every result is back, then go
    // on; the parser state must survive the pause.
    task automatic test_pause_until_drained();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        send_introducer();
        send_byte(osc52_pkg::C_FIVE);
        send_byte(osc52_pkg::C_TWO);
        send_byte(osc52_pkg::C_SEMI);
        send_byte(plain_payload_byte());
        wait_for_results();
        send_byte(plain_payload_byte());
        send_terminator();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        bytes_if.valid   = 1'b0;
        bytes_if.byte_in = '0;
        repeat (ResetCycles)
            @(posedge clk);
        rst_n <= 1'b1;

        test_directed_sequences();
        test_random_stream(PhaseItems, 7, 83);
        test_random_stream(PhaseItems, 83, 7);
        test_output_backpressure();
        test_pause_until_drained();
        test_random_stream(PhaseItems, 0, 0);

        // Drain the output, then let the block settle
        wait_for_results();
        repeat (SettleCycles)
            @(posedge clk);

        $display("Sent %0d bytes: directed corners, random streams under three idle mixes,",
                 bytes_sent);
        $display("a long output hold and a drained pause; %0d payload, %0d done, %0d cancel.",
                 payload_seen, done_seen, cancel_seen);
        if (fail_count == 0 && expected_captures.size() == 0)
            $display("osc52_sequence_capture_filter test passed");
        else
            $display("osc52_sequence_capture_filter test failed");
        $finish;
    end

endmodule

[files.f]
hw/rtl/osc52_pkg.sv
hw/rtl/osc52_byte_if.sv
hw/rtl/osc52_capture_if.sv
hw/rtl/osc52_sequence_capture_filter.sv
verif/tb_top.sv
